/* hdl/cmdg_pkg.sv */
`default_nettype none
package cmdg_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_DEPOSIT    = 2'd0;
    localparam logic [1:0] OP_READ       = 2'd1;
    localparam logic [1:0] OP_READ_CLEAR = 2'd2;
    localparam logic [1:0] OP_UNKNOWN    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_HALF_WORLD    = 2'd0;
    localparam logic [1:0] REG_INV_CELL_SIZE = 2'd1;
    localparam logic [1:0] REG_INV_CELL_AREA = 2'd2;

    // Configuration reset values
    localparam logic [31:0] HALF_WORLD_RST    = 32'd6553600;
    localparam logic [31:0] INV_CELL_SIZE_RST = 32'd83886;
    localparam logic [31:0] INV_CELL_AREA_RST = 32'd107374;

    localparam logic [63:0] DENSITY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [16:0] ONE_Q16     = 17'd65536;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COORD,
        ST_CHECK,
        ST_WEIGHT,
        ST_FACTOR,
        ST_MUL,
        ST_ACC,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* hdl/cic_mass_deposit_grid_unit.sv */
// Cloud-in-cell mass deposit onto a GRID_DIM x GRID_DIM density grid.
// Input channel (in_valid/in_ready): operation, position, mass, cell_address.
// A deposit spreads the mass over four neighbouring cells with bilinear
// weights; a read returns one cell, a read-and-clear also zeroes it.
// Output channel (out_valid/out_ready): deposited, cell_density, saturated,
// one result transaction per input transaction.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while the block is idle.
// A deposit maps its coordinates (scaling, then the grid check), then per
// corner forms weight and factor, four 32x32 partial products of the 64x64
// mass product and a read-modify-write of the one density memory, then loads
// the output register. A read fetches the cell, captures it and, for a
// read-and-clear, zeroes it; an off-grid deposit ends at the grid check; an
// out-of-range read or an unknown code goes straight to the result.
// One transaction is in work at a time; the block is idle again as soon as
// the result is loaded, so it takes a new one while that result still waits.
// Reset: a clearing pass writes zero to every cell with in_ready low;
// configuration writes are taken throughout.
// A stalled receiver holds the result in the output register; a finished
// transaction then waits in its last state until the register frees.
`default_nettype none
module cic_mass_deposit_grid_unit
    import cmdg_pkg::*;
#(
    parameter int GRID_DIM = 256
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic [63:0]        particle_mass,
    input  wire logic [15:0]        cell_address,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               deposited,
    output      logic [63:0]        cell_density,
    output      logic               saturated
);

    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_DIM);
    localparam logic [49:0] G_LIMIT = 50'(GRID_DIM - 1) << 16;

    // Configuration registers
    logic [31:0] half_world_reg, inv_cell_size_reg, inv_cell_area_reg;

    // Control
    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [1:0]    corner_reg;
    logic [1:0]    k_reg;

    // Transaction payload
    logic [1:0]         op_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [63:0]        mass_reg;
    logic [15:0]        addr_reg;

    // Coordinate mapping
    logic        negx_reg, negy_reg;
    logic [48:0] xhi_reg, yhi_reg;
    logic [47:0] xlo_reg, ylo_reg;
    logic [CW-1:0] ix_reg, iy_reg;
    logic [15:0]   fx_reg, fy_reg;

    // Weight, factor and mass product
    logic [32:0]  w_reg;
    logic [63:0]  factor_reg;
    logic [127:0] prod_reg;

    // Result under construction and output register
    logic        res_dep_reg, res_sat_reg;
    logic [63:0] res_den_reg;
    logic        out_valid_reg, out_dep_reg, out_sat_reg;
    logic [63:0] out_den_reg;

    // Density memory
    logic [63:0]   density_mem [CELLS];
    logic [63:0]   rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wdata;

    logic        accept, out_free, addr_ok;
    logic [33:0] sx, sy;
    logic [49:0] gx, gy;
    logic        on_grid;
    logic [16:0] wx, wy;
    logic [CW:0] corner_row;
    logic [AW-1:0] row_ext, corner_addr;
    logic [31:0] mul_a, mul_b;
    logic [63:0] pp;
    logic [127:0] pp_shifted;
    logic        clip_share, clip_sum;
    logic [63:0] share;
    logic [64:0] sum;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign addr_ok   = (32'(cell_address) < 32'(CELLS));

    assign out_valid    = out_valid_reg;
    assign deposited    = out_dep_reg;
    assign cell_density = out_den_reg;
    assign saturated    = out_sat_reg;

    // Shift positions into the non-negative range
    assign sx = {{2{px_reg[31]}}, px_reg} + {2'b00, half_world_reg};
    assign sy = {{2{py_reg[31]}}, py_reg} + {2'b00, half_world_reg};

    // Combine high and low partial products into grid units
    assign gx = 50'(xhi_reg) + 50'(xlo_reg[47:16]);
    assign gy = 50'(yhi_reg) + 50'(ylo_reg[47:16]);
    assign on_grid = !negx_reg && !negy_reg && (gx < G_LIMIT) && (gy < G_LIMIT);

    // Axis weights of the current corner
    assign wx = corner_reg[0] ? {1'b0, fx_reg} : ONE_Q16 - {1'b0, fx_reg};
    assign wy = corner_reg[1] ? {1'b0, fy_reg} : ONE_Q16 - {1'b0, fy_reg};

    // Cell index of the current corner
    assign corner_row  = {1'b0, iy_reg} + (CW + 1)'(corner_reg[1]);
    assign row_ext     = AW'(corner_row);
    assign corner_addr = AW'(row_ext * AW'(GRID_DIM)) + AW'(ix_reg) + AW'(corner_reg[0]);

    // One 32x32 partial product of mass times factor per cycle
    assign mul_a = k_reg[1] ? mass_reg[63:32] : mass_reg[31:0];
    assign mul_b = k_reg[0] ? factor_reg[63:32] : factor_reg[31:0];
    assign pp    = 64'(mul_a) * 64'(mul_b);
    always_comb
    begin
        case (k_reg)
            2'd0:    pp_shifted = 128'(pp);
            2'd3:    pp_shifted = 128'(pp) << 64;
            default: pp_shifted = 128'(pp) << 32;
        endcase
    end

    // Drop the 48 fraction bits of the Q16.48 factor from the product and add to the cell with saturation
    assign clip_share = |prod_reg[127:112];
    assign share      = clip_share ? DENSITY_MAX : prod_reg[111:48];
    assign sum        = {1'b0, rdata_reg} + {1'b0, share};
    assign clip_sum   = sum[64];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == AW'(CELLS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    if (operation == OP_DEPOSIT)
                        state_next = ST_COORD;
                    else if ((operation == OP_READ || operation == OP_READ_CLEAR) && addr_ok)
                        state_next = ST_READ;
                    else
                        state_next = ST_DONE;
                end
            ST_COORD:     state_next = ST_CHECK;
            ST_CHECK:     state_next = on_grid ? ST_WEIGHT : ST_DONE;
            ST_WEIGHT:    state_next = ST_FACTOR;
            ST_FACTOR:    state_next = ST_MUL;
            ST_MUL:
                if (k_reg == 2'd3)
                    state_next = ST_ACC;
            ST_ACC:       state_next = (corner_reg == 2'd3) ? ST_DONE : ST_WEIGHT;
            ST_READ:      state_next = ST_READ_DATA;
            ST_READ_DATA: state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = corner_addr;
        mem_raddr = corner_addr;
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            ST_MUL:
                mem_re = (k_reg == 2'd3);
            ST_ACC:
            begin
                mem_we    = 1'b1;
                mem_wdata = clip_sum ? DENSITY_MAX : sum[63:0];
            end
            ST_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(addr_reg);
            end
            ST_READ_DATA:
            begin
                mem_we    = (op_reg == OP_READ_CLEAR);
                mem_waddr = AW'(addr_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Density memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            density_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= density_mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_reg           <= '0;
            corner_reg        <= '0;
            k_reg             <= '0;
            out_valid_reg     <= 1'b0;
            half_world_reg    <= HALF_WORLD_RST;
            inv_cell_size_reg <= INV_CELL_SIZE_RST;
            inv_cell_area_reg <= INV_CELL_AREA_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HALF_WORLD:    half_world_reg    <= cfg_data;
                    REG_INV_CELL_SIZE: inv_cell_size_reg <= cfg_data;
                    REG_INV_CELL_AREA: inv_cell_area_reg <= cfg_data;
                    default:           half_world_reg    <= half_world_reg;
                endcase
            end
            if (state_reg == ST_CHECK)
                corner_reg <= '0;
            else if (state_reg == ST_ACC)
                corner_reg <= corner_reg + 2'd1;
            if (state_reg == ST_MUL)
                k_reg <= k_reg + 2'd1;
            else
                k_reg <= '0;
            // Hand the result to the output register or drop it once taken
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= operation;
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            mass_reg    <= particle_mass;
            addr_reg    <= cell_address;
            res_dep_reg <= 1'b0;
            res_sat_reg <= 1'b0;
            res_den_reg <= '0;
        end
        case (state_reg)
            ST_COORD:
            begin
                negx_reg <= sx[33];
                negy_reg <= sy[33];
                xhi_reg  <= 49'(sx[32:16]) * 49'(inv_cell_size_reg);
                xlo_reg  <= 48'(sx[15:0]) * 48'(inv_cell_size_reg);
                yhi_reg  <= 49'(sy[32:16]) * 49'(inv_cell_size_reg);
                ylo_reg  <= 48'(sy[15:0]) * 48'(inv_cell_size_reg);
            end
            ST_CHECK:
            begin
                ix_reg      <= gx[16 +: CW];
                iy_reg      <= gy[16 +: CW];
                fx_reg      <= gx[15:0];
                fy_reg      <= gy[15:0];
                res_dep_reg <= on_grid;
            end
            ST_WEIGHT:
                w_reg <= 33'(34'(wx) * 34'(wy));
            ST_FACTOR:
            begin
                factor_reg <= 64'(65'(w_reg) * 65'(inv_cell_area_reg));
                prod_reg   <= '0;
            end
            ST_MUL:
                prod_reg <= prod_reg + pp_shifted;
            ST_ACC:
                res_sat_reg <= res_sat_reg | clip_share | clip_sum;
            ST_READ_DATA:
                res_den_reg <= rdata_reg;
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free)
        begin
            out_dep_reg <= res_dep_reg;
            out_sat_reg <= res_sat_reg;
            out_den_reg <= res_den_reg;
        end
    end

    // No transaction is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("input accepted during clearing pass");

    // One transaction in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second transaction accepted while one is in work");

    // Deposit results carry no density
    a_dep_no_density: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && deposited) |-> (cell_density == 64'd0))
        else $error("deposit result carries a density");

    // Saturation is only reported for a deposit that was added
    a_sat_needs_dep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> deposited)
        else $error("saturation flagged without a deposit");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
module testbench;
    import cmdg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID    = 256;
    localparam int WD_LIMIT = 300000;

    typedef struct packed {
        logic        deposited;
        logic [63:0] density;
        logic        saturated;
    } cell_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic [63:0]        particle_mass = '0;
    logic [15:0]        cell_address = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               deposited;
    logic [63:0]        cell_density;
    logic               saturated;

    cic_mass_deposit_grid_unit #(.GRID_DIM(GRID)) DUT (.*);

    always #5 clk = ~clk;

    // Predictor state
    logic [31:0]  half_world_q;
    logic [31:0]  inv_size_q;
    logic [31:0]  inv_area_q;
    logic [63:0]  grid_mass [GRID*GRID];
    cell_result_t pending_cells[$];
    int           touched_cells[$];

    int  error_count = 0;
    int  result_count = 0;
    int  deposit_hits = 0;
    int  clip_hits = 0;
    int  item_count = 0;
    bit  no_idle = 1'b0;
    int  quiet_cycles = 0;

    // Map one signed Q16.16 coordinate to cell and fraction
    function automatic bit map_axis(input logic [31:0] raw, output int cell_idx,
                                    output logic [15:0] frac);
        logic signed [63:0] shifted;
        logic [63:0]        u;
        logic [63:0]        g;
        shifted = 64'(signed'(raw)) + $signed({32'b0, half_world_q});
        cell_idx = 0;
        frac = '0;
        if (shifted < 0)
            return 1'b0;
        u = shifted;
        g = (u >> 16) * inv_size_q + (((u & 64'hFFFF) * inv_size_q) >> 16);
        if (g >= (64'(GRID - 1) << 16))
            return 1'b0;
        cell_idx = int'(g >> 16);
        frac = g[15:0];
        return 1'b1;
    endfunction

    // Add one weighted share into a cell; return 1 on clipping
    function automatic bit spread_share(input int idx, input logic [63:0] weight,
                                        input logic [63:0] mass);
        logic [63:0]  factor;
        logic [127:0] prod;
        logic [63:0]  share;
        logic [64:0]  total;
        bit           clip;
        factor = weight * inv_area_q;
        prod = {64'b0, mass} * {64'b0, factor};
        clip = 1'b0;
        if (prod[127:112] != 0) begin
            share = DENSITY_MAX;
            clip = 1'b1;
        end else begin
            share = prod[111:48];
        end
        total = {1'b0, grid_mass[idx]} + {1'b0, share};
        if (total[64]) begin
            grid_mass[idx] = DENSITY_MAX;
            clip = 1'b1;
        end else begin
            grid_mass[idx] = total[63:0];
        end
        return clip;
    endfunction

    // Compute the expected cell result of one transaction and update the grid
    function automatic cell_result_t deposit_predict(input logic [1:0] op,
            input logic [31:0] px, input logic [31:0] py, input logic [63:0] mass,
            input logic [15:0] addr);
        cell_result_t r;
        int           ix, iy, base;
        logic [15:0]  fx, fy;
        logic [63:0]  wx0, wx1, wy0, wy1;
        bit           clip;
        r = '0;
        if (op == OP_DEPOSIT) begin
            if (map_axis(px, ix, fx) && map_axis(py, iy, fy)) begin
                base = iy * GRID + ix;
                wx1 = fx;
                wy1 = fy;
                wx0 = 64'(ONE_Q16) - wx1;
                wy0 = 64'(ONE_Q16) - wy1;
                clip = spread_share(base, wx0 * wy0, mass);
                clip |= spread_share(base + 1, wx1 * wy0, mass);
                clip |= spread_share(base + GRID, wx0 * wy1, mass);
                clip |= spread_share(base + GRID + 1, wx1 * wy1, mass);
                r.deposited = 1'b1;
                r.saturated = clip;
                touched_cells.push_back(base);
                if (touched_cells.size() > 64)
                    void'(touched_cells.pop_front());
            end
        end else if (op == OP_READ || op == OP_READ_CLEAR) begin
            if (int'(addr) < GRID * GRID) begin
                r.density = grid_mass[addr];
                if (op == OP_READ_CLEAR)
                    grid_mass[addr] = '0;
            end
        end
        return r;
    endfunction

    // Send one transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] op, input logic [31:0] px,
                             input logic [31:0] py, input logic [63:0] mass,
                             input logic [15:0] addr);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        pos_x <= px;
        pos_y <= py;
        particle_mass <= mass;
        cell_address <= addr;
        do @(posedge clk); while (!in_ready);
        pending_cells.push_back(deposit_predict(op, px, py, mass, addr));
        item_count++;
    endtask

    // Wait until every expected result has arrived, then let the block settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_HALF_WORLD:    half_world_q = value;
            REG_INV_CELL_SIZE: inv_size_q = value;
            REG_INV_CELL_AREA: inv_area_q = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] on_grid_pos();
        return 32'($urandom_range(13107199)) - 32'd6553600;
    endfunction

    function automatic logic [63:0] random_mass();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(3))
            0: m = m >> $urandom_range(63);
            1: m = m >> 40;
            default: m = m >> 20;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] near_cell();
        int base;
        if (touched_cells.size() == 0)
            return 16'($urandom);
        base = touched_cells[$urandom_range(touched_cells.size() - 1)];
        case ($urandom_range(3))
            0: return 16'(base);
            1: return 16'(base + 1);
            2: return 16'(base + GRID);
            default: return 16'(base + GRID + 1);
        endcase
    endfunction

    // One random transaction: mostly on-grid deposits and reads of touched cells
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            send_item(OP_DEPOSIT, on_grid_pos(), on_grid_pos(), random_mass(), 16'($urandom));
        else if (pick < 70)
            send_item(OP_READ, $urandom, $urandom, {$urandom, $urandom}, near_cell());
        else if (pick < 82)
            send_item(OP_READ_CLEAR, $urandom, $urandom, {$urandom, $urandom}, near_cell());
        else if (pick < 92)
            send_item(OP_DEPOSIT, $urandom, $urandom, {$urandom, $urandom}, 16'($urandom));
        else if (pick < 96)
            send_item(OP_READ, $urandom, $urandom, {$urandom, $urandom}, 16'($urandom));
        else
            send_item(OP_UNKNOWN, $urandom, $urandom, {$urandom, $urandom}, 16'($urandom));
    endtask

    // Field extremes, grid edges, saturation, read and clear, unknown code
    task automatic test_directed();
        send_item(OP_DEPOSIT, 32'hFF9C_0000, 32'hFF9C_0000, 64'h0001_0000_0000_0000, 16'h0);
        send_item(OP_READ, '0, '0, '0, 16'd0);
        send_item(OP_READ, '0, '0, '0, 16'd1);
        send_item(OP_DEPOSIT, 32'h0063_8000, 32'h0063_8000, 64'h0000_8000_0000_0000, 16'hFFFF);
        send_item(OP_DEPOSIT, 32'h0064_0000, 32'h0000_0000, 64'h0001_0000_0000_0000, 16'h0);
        send_item(OP_DEPOSIT, 32'hFF9B_FFFF, 32'h0000_0000, 64'h0001_0000_0000_0000, 16'h0);
        send_item(OP_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_item(OP_DEPOSIT, 32'h0000_8000, 32'h0001_4000, 64'h0, 16'h0);
        send_item(OP_DEPOSIT, 32'h0000_8000, 32'h0001_4000, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_item(OP_DEPOSIT, 32'h0000_8000, 32'h0001_4000, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_item(OP_READ, '0, '0, '0, near_cell());
        send_item(OP_READ_CLEAR, '1, '1, '1, near_cell());
        send_item(OP_READ_CLEAR, '0, '0, '0, 16'd0);
        send_item(OP_READ, '0, '0, '0, 16'd0);
        send_item(OP_READ, '0, '0, '0, 16'hFFFF);
        send_item(OP_READ_CLEAR, '0, '0, '0, 16'hFFFF);
        send_item(OP_UNKNOWN, '1, '1, '1, 16'hFFFF);
        send_item(OP_UNKNOWN, '0, '0, '0, 16'd0);
        drain();
    endtask

    // Random traffic at the reset configuration, first stretch without idling
    task automatic test_reset_config();
        no_idle = 1'b1;
        repeat (150) random_item();
        no_idle = 1'b0;
        repeat (750) random_item();
        drain();
    endtask

    // Walk the configuration through its extremes and random settings
    task automatic test_config_sweep();
        logic [31:0] hw_set [7] = '{32'd0, 32'hFFFF_FFFF, 32'd6553600, 32'd3276800,
                                    32'h0, 32'h0000_8000, 32'd6553600};
        logic [31:0] sz_set [7] = '{32'd83886, 32'd0, 32'hFFFF_FFFF, 32'd167772,
                                    32'h0001_0000, 32'd83886, 32'd83886};
        logic [31:0] ar_set [7] = '{32'hFFFF_FFFF, 32'd107374, 32'd0, 32'd65536,
                                    32'h0, 32'hFFFF_FFFF, 32'd107374};
        for (int s = 0; s < 7; s++) begin
            write_reg(REG_HALF_WORLD, (s == 3) ? $urandom : hw_set[s]);
            write_reg(REG_INV_CELL_SIZE, sz_set[s]);
            write_reg(REG_INV_CELL_AREA, (s == 3) ? $urandom : ar_set[s]);
            repeat (110) random_item();
            drain();
        end
    endtask

    // Result checker
    always @(posedge clk) begin
        cell_result_t want;
        if (out_valid && out_ready) begin
            result_count++;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected result deposited=%0b density=%h saturated=%0b",
                         $time, deposited, cell_density, saturated);
                error_count++;
            end else begin
                want = pending_cells.pop_front();
                deposit_hits += deposited;
                clip_hits += saturated;
                if (deposited !== want.deposited) begin
                    $display("%0t: deposited expected %0b actual %0b",
                             $time, want.deposited, deposited);
                    error_count++;
                end
                if (cell_density !== want.density) begin
                    $display("%0t: cell_density expected %h actual %h",
                             $time, want.density, cell_density);
                    error_count++;
                end
                if (saturated !== want.saturated) begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.saturated, saturated);
                    error_count++;
                end
            end
        end
    end

    // Stall the result channel at random
    always @(negedge clk)
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        half_world_q = HALF_WORLD_RST;
        inv_size_q = INV_CELL_SIZE_RST;
        inv_area_q = INV_CELL_AREA_RST;
        foreach (grid_mass[i])
            grid_mass[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_reset_config();
        test_config_sweep();
        drain();
        repeat (40) @(posedge clk);
        $display("Sent %0d transactions, checked %0d results under 8 register settings.",
                 item_count, result_count);
        $display("On-grid deposits: %0d, clipped deposits: %0d, mismatches: %0d.",
                 deposit_hits, clip_hits, error_count);
        if (error_count == 0 && pending_cells.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
